### rtl/voxel_ray_traversal_top_defines.svh
// assertion helpers shared by the rtl files
`ifndef VOXEL_RAY_TRAVERSAL_TOP_DEFINES_SVH
`define VOXEL_RAY_TRAVERSAL_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define VRT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vrt assertion failed");

// next-cycle implication, checked outside reset
`define VRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vrt assertion failed");

`endif

### rtl/vrt_pkg.sv
`default_nettype none
package vrt_pkg;

    localparam int MAX_STEPS_DEF       = 64;
    localparam int COORD_FRAC_BITS_DEF = 8;

    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 168;
    localparam int VOX_W      = 24;
    localparam int T_W        = 32;
    localparam int ITER_W     = 5;

    localparam logic [T_W-1:0]    T_INF     = 32'hFFFF_FFFF;
    localparam logic [T_W-1:0]    T_MAXF    = 32'hFFFF_FFFE;
    localparam logic [ITER_W-1:0] ITER_LAST = 5'd31;

    localparam logic       CMD_START  = 1'b0;
    localparam logic       CMD_ANSWER = 1'b1;

    localparam logic [1:0] KIND_PROBE = 2'd0;
    localparam logic [1:0] KIND_HIT   = 2'd1;
    localparam logic [1:0] KIND_MISS  = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_SQ,
        S_CHK,
        S_SQRT,
        S_AXIS,
        S_DIV,
        S_MUL,
        S_BND,
        S_STEP,
        S_RCHK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic       load;
        logic       sq_en;
        logic       sqrt_init;
        logic       sqrt_en;
        logic       axis_init;
        logic       div_en;
        logic       mul_en;
        logic       bnd_en;
        logic       step_en;
        logic       set_busy;
        logic       clr_busy;
        logic       out_load;
        logic [1:0] kind;
        logic [1:0] axis;
    } t_dp_cmd;

    typedef struct packed {
        logic is_start;
        logic busy;
        logic solid;
        logic reach_zero;
        logic lsq_zero;
        logic d_zero;
        logic steps_max;
        logic reach_exceed;
        logic out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

### rtl/voxel_ray_traversal_top.sv
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tuser command, tdata ray or answer
// m_axis    out  m_axis_tvalid/tready      tuser kind, tdata voxel, normal, place, distance
//
// a start word runs decode, the sum of squares over the three axes, a check and the digit-serial
// root, then per moving axis a divide and a boundary multiply, while a still axis only loads its
// voxel, and then the emit
// an answer word runs a dda step and a reach check, or goes straight to the emit for a hit or
// step-limit miss; the emit can wait on the m_axis output register
// one word is worked at a time; s_axis_tready is high only while the sequencer idles
// synchronous active-low reset clears the sequencer, the busy flag and the output valid
`default_nettype none
module voxel_ray_traversal_top
    import vrt_pkg::*;
#(
    parameter int MAX_STEPS       = MAX_STEPS_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_reach, solid
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // command
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // voxel_x/y/z, normal_x/y/z, place_x/y/z, distance
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // kind
    output logic [1:0]                 m_axis_tuser
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer: setup iterations, dda step and result word hand-off
    vrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // datapath: root, divider, boundary multiply, walk state and output register
    vrt_dp #(
        .MAX_STEPS       (MAX_STEPS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_axis_tdata),
        .i_in_cmd    (s_axis_tuser),
        .o_out_data  (m_axis_tdata),
        .o_out_kind  (m_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

endmodule
`default_nettype wire

### rtl/vrt_ctrl.sv
`default_nettype none
`include "voxel_ray_traversal_top_defines.svh"
module vrt_ctrl
    import vrt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state            r_state, n_state;
    logic [ITER_W-1:0] r_cnt, n_cnt;
    logic [1:0]        r_axis, n_axis;
    logic [1:0]        r_kind, n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_axis  <= AXIS_X;
            r_kind  <= KIND_PROBE;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_axis  <= n_axis;
            r_kind  <= n_kind;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_axis  = r_axis;
        n_kind  = r_kind;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DEC;
            end
            S_DEC: begin
                if (i_stat.is_start) begin
                    n_state = S_SQ;
                    n_axis  = AXIS_X;
                end else if (!i_stat.busy) begin
                    n_state = S_IDLE;
                end else if (i_stat.solid) begin
                    n_state = S_EMIT;
                    n_kind  = KIND_HIT;
                end else if (i_stat.steps_max) begin
                    n_state = S_EMIT;
                    n_kind  = KIND_MISS;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_SQ: begin
                if (r_axis == AXIS_Z) begin
                    n_state = S_CHK;
                    n_axis  = AXIS_X;
                end else begin
                    n_axis = r_axis + 2'd1;
                end
            end
            S_CHK: begin
                if (i_stat.reach_zero || i_stat.lsq_zero) begin
                    n_state = S_EMIT;
                    n_kind  = KIND_MISS;
                end else begin
                    n_state = S_SQRT;
                    n_cnt   = '0;
                end
            end
            S_SQRT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == ITER_LAST) begin
                    n_state = S_AXIS;
                    n_axis  = AXIS_X;
                end
            end
            S_AXIS: begin
                if (!i_stat.d_zero) begin
                    n_state = S_DIV;
                    n_cnt   = '0;
                end else if (r_axis == AXIS_Z) begin
                    n_state = S_EMIT;
                    n_kind  = KIND_PROBE;
                end else begin
                    n_axis = r_axis + 2'd1;
                end
            end
            S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == ITER_LAST) n_state = S_MUL;
            end
            S_MUL: n_state = S_BND;
            S_BND: begin
                if (r_axis == AXIS_Z) begin
                    n_state = S_EMIT;
                    n_kind  = KIND_PROBE;
                end else begin
                    n_state = S_AXIS;
                    n_axis  = r_axis + 2'd1;
                end
            end
            S_STEP: n_state = S_RCHK;
            S_RCHK: begin
                n_state = S_EMIT;
                n_kind  = i_stat.reach_exceed ? KIND_MISS : KIND_PROBE;
            end
            S_EMIT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_cmd.axis = r_axis;
        o_cmd.kind = r_kind;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DEC: begin
                if (i_stat.is_start) begin
                    o_cmd.clr_busy = 1'b1;
                end else if (i_stat.busy && (i_stat.solid || i_stat.steps_max)) begin
                    o_cmd.clr_busy = 1'b1;
                end
            end
            S_SQ:   o_cmd.sq_en = 1'b1;
            S_CHK: begin
                if (!(i_stat.reach_zero || i_stat.lsq_zero)) o_cmd.sqrt_init = 1'b1;
            end
            S_SQRT: o_cmd.sqrt_en = 1'b1;
            S_AXIS: begin
                o_cmd.axis_init = 1'b1;
                if (i_stat.d_zero && r_axis == AXIS_Z) o_cmd.set_busy = 1'b1;
            end
            S_DIV:  o_cmd.div_en = 1'b1;
            S_MUL:  o_cmd.mul_en = 1'b1;
            S_BND: begin
                o_cmd.bnd_en = 1'b1;
                if (r_axis == AXIS_Z) o_cmd.set_busy = 1'b1;
            end
            S_STEP: o_cmd.step_en = 1'b1;
            S_RCHK: begin
                if (i_stat.reach_exceed) o_cmd.clr_busy = 1'b1;
            end
            S_EMIT: o_cmd.out_load = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

    `VRT_ASSERT_NEXT(a_accept_leaves_idle, i_in_valid && o_in_ready, r_state == S_DEC)
    `VRT_ASSERT_NEXT(a_sqrt_to_axis, r_state == S_SQRT && r_cnt == ITER_LAST, r_state == S_AXIS)

endmodule
`default_nettype wire

### rtl/vrt_dp.sv
`default_nettype none
`include "voxel_ray_traversal_top_defines.svh"
module vrt_dp
    import vrt_pkg::*;
#(
    parameter int MAX_STEPS       = MAX_STEPS_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [IN_DATA_W-1:0]  i_in_data,
    input  wire logic                  i_in_cmd,
    output logic [OUT_DATA_W-1:0]      o_out_data,
    output logic [1:0]                 o_out_kind,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat
);

    localparam int DIST_W = COORD_FRAC_BITS + 1;
    localparam int PROD_W = DIST_W + T_W;
    localparam int STEP_W = $clog2(MAX_STEPS + 1);
    localparam logic [31:0] FMASK = (32'd1 << COORD_FRAC_BITS) - 32'd1;
    localparam logic [31:0] FONE  = 32'd1 << COORD_FRAC_BITS;

    // latched item
    logic [31:0]        r_org [3];
    logic signed [15:0] r_dir [3];
    logic [15:0]        r_reach;
    logic               r_solid;
    logic               r_is_start;

    // walk state
    logic               r_busy;
    logic [VOX_W-1:0]   r_vox [3];
    logic signed [1:0]  r_sign [3];
    logic [T_W-1:0]     r_tnb [3];
    logic [T_W-1:0]     r_tdel [3];
    logic [T_W-1:0]     r_cur_t;
    logic signed [1:0]  r_nrm [3];
    logic [STEP_W-1:0]  r_steps;
    logic               r_origin_probe;

    // setup units
    logic [31:0]        r_lsq;
    logic [31:0]        r_rad;
    logic [33:0]        r_rem;
    logic [31:0]        r_root;
    logic [31:0]        r_dq;
    logic [15:0]        r_drem;
    logic [PROD_W-1:0]  r_prod;

    logic                 r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [1:0]           r_out_kind;

    logic signed [15:0] w_d;
    logic [15:0]        w_ad;
    logic [31:0]        w_sq;
    logic [35:0]        w_rsh, w_trial;
    logic [16:0]        w_ds;
    logic [31:0]        w_tdsat, w_org, w_frac, w_vfull;
    logic [DIST_W-1:0]  w_dist;
    logic [PROD_W-1:0]  w_shift;
    logic [T_W-1:0]     w_bnd;
    logic [1:0]         w_ax;
    logic [T_W-1:0]     w_tmin, w_nb;
    logic [T_W:0]       w_sum;
    logic               w_out_free;
    logic [OUT_DATA_W-1:0] w_out;

    assign w_d    = r_dir[i_cmd.axis];
    assign w_ad   = w_d[15] ? (~w_d + 16'd1) : w_d;
    assign w_sq   = {16'd0, w_ad} * {16'd0, w_ad};
    assign w_org  = r_org[i_cmd.axis];
    assign w_frac = w_org & FMASK;
    assign w_vfull = 32'($signed(w_org) >>> COORD_FRAC_BITS);
    assign w_dist = w_d[15] ? DIST_W'(w_frac) : DIST_W'(FONE - w_frac);

    // digit-serial square root, two radicand bits a cycle
    assign w_rsh   = {r_rem, r_rad[31:30]};
    assign w_trial = {2'b00, r_root, 2'b01};

    // restoring division, one quotient bit a cycle
    assign w_ds    = {r_drem, r_dq[31]};
    assign w_tdsat = (r_dq == T_INF) ? T_MAXF : r_dq;

    assign w_shift = r_prod >> COORD_FRAC_BITS;
    assign w_bnd   = (w_shift > PROD_W'(T_MAXF)) ? T_MAXF : w_shift[T_W-1:0];

    // axis pick, ties go y over x and z over both
    always_comb begin
        if (r_tnb[0] < r_tnb[1]) w_ax = (r_tnb[0] < r_tnb[2]) ? AXIS_X : AXIS_Z;
        else                     w_ax = (r_tnb[1] < r_tnb[2]) ? AXIS_Y : AXIS_Z;
    end
    assign w_tmin = r_tnb[w_ax];
    assign w_sum  = {1'b0, w_tmin} + {1'b0, r_tdel[w_ax]};
    always_comb begin
        if (w_tmin == T_INF || r_tdel[w_ax] == T_INF) w_nb = T_INF;
        else if (w_sum > {1'b0, T_MAXF})            w_nb = T_MAXF;
        else                                        w_nb = w_sum[T_W-1:0];
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    // result word: probe carries the voxel only, a hit adds normal, place and distance, a miss carries nothing
    always_comb begin
        w_out = '0;
        if (i_cmd.kind == KIND_PROBE || i_cmd.kind == KIND_HIT) begin
            w_out[71:0] = {r_vox[2], r_vox[1], r_vox[0]};
        end
        if (i_cmd.kind == KIND_HIT) begin
            if (r_origin_probe) begin
                w_out[77:72]  = {2'sd0, 2'sd1, 2'sd0};
                w_out[149:78] = {r_vox[2], r_vox[1] + VOX_W'(1), r_vox[0]};
            end else begin
                w_out[77:72]   = {r_nrm[2], r_nrm[1], r_nrm[0]};
                w_out[149:78]  = {r_vox[2] + VOX_W'(signed'(r_nrm[2])),
                                  r_vox[1] + VOX_W'(signed'(r_nrm[1])),
                                  r_vox[0] + VOX_W'(signed'(r_nrm[0]))};
                w_out[165:150] = r_cur_t[23:8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_org[0]   <= i_in_data[31:0];
            r_org[1]   <= i_in_data[63:32];
            r_org[2]   <= i_in_data[95:64];
            r_dir[0]   <= i_in_data[111:96];
            r_dir[1]   <= i_in_data[127:112];
            r_dir[2]   <= i_in_data[143:128];
            r_is_start <= (i_in_cmd == CMD_START);
            r_solid    <= i_in_data[160];
            if (i_in_cmd == CMD_START) r_reach <= i_in_data[159:144];
            r_lsq      <= '0;
        end
        if (i_cmd.sq_en) r_lsq <= r_lsq + w_sq;
        if (i_cmd.sqrt_init) begin
            r_rad          <= r_lsq;
            r_rem          <= '0;
            r_root         <= '0;
            r_cur_t        <= '0;
            r_steps        <= '0;
            r_origin_probe <= 1'b1;
            for (int i = 0; i < 3; i++) r_nrm[i] <= '0;
        end
        if (i_cmd.sqrt_en) begin
            r_rad <= {r_rad[29:0], 2'b00};
            if (w_rsh >= w_trial) begin
                r_rem  <= 34'(w_rsh - w_trial);
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem  <= w_rsh[33:0];
                r_root <= {r_root[30:0], 1'b0};
            end
        end
        if (i_cmd.axis_init) begin
            r_vox[i_cmd.axis] <= w_vfull[VOX_W-1:0];
            r_dq              <= r_root;
            r_drem            <= '0;
            if (w_d == 16'sd0) begin
                r_sign[i_cmd.axis] <= 2'sd0;
                r_tdel[i_cmd.axis] <= T_INF;
                r_tnb[i_cmd.axis]  <= T_INF;
            end else begin
                r_sign[i_cmd.axis] <= w_d[15] ? -2'sd1 : 2'sd1;
            end
        end
        if (i_cmd.div_en) begin
            if (w_ds >= {1'b0, w_ad}) begin
                r_drem <= 16'(w_ds - {1'b0, w_ad});
                r_dq   <= {r_dq[30:0], 1'b1};
            end else begin
                r_drem <= w_ds[15:0];
                r_dq   <= {r_dq[30:0], 1'b0};
            end
        end
        if (i_cmd.mul_en) begin
            r_tdel[i_cmd.axis] <= w_tdsat;
            r_prod             <= PROD_W'(w_dist) * PROD_W'(w_tdsat);
        end
        if (i_cmd.bnd_en) r_tnb[i_cmd.axis] <= w_bnd;
        if (i_cmd.step_en) begin
            r_steps        <= r_steps + 1'b1;
            r_cur_t        <= w_tmin;
            r_tnb[w_ax]    <= w_nb;
            r_vox[w_ax]    <= r_vox[w_ax] + VOX_W'(signed'(r_sign[w_ax]));
            r_origin_probe <= 1'b0;
            for (int i = 0; i < 3; i++)
                r_nrm[i] <= (2'(i) == w_ax) ? -r_sign[w_ax] : 2'sd0;
        end
        if (i_cmd.out_load) begin
            r_out_kind <= i_cmd.kind;
            r_out_data <= w_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_busy)      r_busy <= 1'b0;
            else if (i_cmd.set_busy) r_busy <= 1'b1;
            if (i_cmd.out_load)      r_out_valid <= 1'b1;
            else if (i_out_ready)    r_out_valid <= 1'b0;
        end
    end

    assign o_out_data  = r_out_data;
    assign o_out_kind  = r_out_kind;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_stat.is_start     = r_is_start;
        o_stat.busy         = r_busy;
        o_stat.solid        = r_solid;
        o_stat.reach_zero   = (r_reach == 16'd0);
        o_stat.lsq_zero     = (r_lsq == 32'd0);
        o_stat.d_zero       = (w_d == 16'sd0);
        o_stat.steps_max    = (r_steps >= STEP_W'(MAX_STEPS));
        o_stat.reach_exceed = (r_cur_t > {8'd0, r_reach, 8'd0});
        o_stat.out_free     = w_out_free;
    end

    `VRT_ASSERT_NOW(a_no_overwrite, i_cmd.out_load, w_out_free)
    `VRT_ASSERT_NEXT(a_step_leaves_origin, i_cmd.step_en, !r_origin_probe)

endmodule
`default_nettype wire
